// File: rtl/bcdec_pkg.sv
// ----------------------------------------------------------------------------
// bcdec_pkg
// Shared types, constants and arithmetic helpers for the BC1/BC2/BC3 decoder.
// ----------------------------------------------------------------------------
package bcdec_pkg;

  localparam logic [13:0] MAX_DIMENSION = 14'd8192;
  localparam logic [3:0]  LAST_PIXEL    = 4'd15;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // Per-block data carried alongside the palette
  typedef struct packed {
    logic [31:0] indices;
    logic [63:0] alpha_bits;
    logic [10:0] col;
    logic [10:0] row;
    logic        dxt3;
    logic        dxt5;
  } blk_t;

  typedef struct packed {
    logic [15:0] color0;
    logic [15:0] color1;
    blk_t        blk;
  } raw_t;

  // Palette entries hold {r, g, b}; opaque3 is the DXT1 alpha of entry 3
  typedef struct packed {
    logic [3:0][23:0] rgb;
    logic             opaque3;
    logic [7:0][7:0]  atab;
  } pal_t;

  function automatic logic [23:0] expand565(logic [15:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

  // Reciprocal multiply, exact for x < 768
  function automatic logic [7:0] div3(logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // Reciprocal multiply, exact for x < 1280
  function automatic logic [7:0] div5(logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd1639;
    return p[20:13];
  endfunction

  // Reciprocal multiply, exact for x < 1792
  function automatic logic [7:0] div7(logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd2341;
    return p[21:14];
  endfunction

  function automatic logic [13:0] clamp_dim(logic [13:0] d);
    logic [13:0] r;
    if (d == 14'd0) begin
      r = 14'd1;
    end else if (d > MAX_DIMENSION) begin
      r = MAX_DIMENSION;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// File: rtl/bcdec_palette.sv
// ----------------------------------------------------------------------------
// bcdec_palette
// Builds the four-entry color palette and the eight-entry DXT5 alpha table.
// ----------------------------------------------------------------------------
module bcdec_palette (
  input  logic [15:0]     color0_i,
  input  logic [15:0]     color1_i,
  input  logic [15:0]     alpha_ends_i,
  input  logic            four_color_i,
  output bcdec_pkg::pal_t pal_o
);

  logic [23:0] exp0;
  logic [23:0] exp1;
  logic [7:0]  a0;
  logic [7:0]  a1;

  assign exp0 = bcdec_pkg::expand565(color0_i);
  assign exp1 = bcdec_pkg::expand565(color1_i);
  assign a0   = alpha_ends_i[7:0];
  assign a1   = alpha_ends_i[15:8];

  always_comb begin
    logic [7:0] c0;
    logic [7:0] c1;
    logic [8:0] sum;
    pal_o = '0;
    pal_o.rgb[0] = exp0;
    pal_o.rgb[1] = exp1;
    for (int ch = 0; ch < 3; ch++) begin
      c0  = exp0[ch*8 +: 8];
      c1  = exp1[ch*8 +: 8];
      sum = {1'b0, c0} + {1'b0, c1};
      if (four_color_i) begin
        pal_o.rgb[2][ch*8 +: 8] = bcdec_pkg::div3({1'b0, c0, 1'b0} + {2'b00, c1});
        pal_o.rgb[3][ch*8 +: 8] = bcdec_pkg::div3({2'b00, c0} + {1'b0, c1, 1'b0});
      end else begin
        pal_o.rgb[2][ch*8 +: 8] = sum[8:1];
        pal_o.rgb[3][ch*8 +: 8] = 8'h00;
      end
    end
    pal_o.opaque3 = four_color_i;

    pal_o.atab[0] = a0;
    pal_o.atab[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i < 7; i++) begin
        pal_o.atab[i+1] = bcdec_pkg::div7(11'((7 - i) * a0 + i * a1));
      end
    end else begin
      for (int i = 1; i < 5; i++) begin
        pal_o.atab[i+1] = bcdec_pkg::div5(11'((5 - i) * a0 + i * a1));
      end
      pal_o.atab[6] = 8'h00;
      pal_o.atab[7] = 8'hFF;
    end
  end

endmodule

// File: rtl/bcdec_emit.sv
// ----------------------------------------------------------------------------
// bcdec_emit
// Holds one decoded block and streams its sixteen pixels, one beat a cycle unless the output stalls.
// ----------------------------------------------------------------------------
module bcdec_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  output logic             load_ready_o,
  input  bcdec_pkg::blk_t  blk_i,
  input  bcdec_pkg::pal_t  pal_i,
  input  logic [13:0]      width_i,
  input  logic [13:0]      height_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic [12:0]      pixel_x_o,
  output logic [12:0]      pixel_y_o,
  output logic             inside_res_o,
  output logic             last_o
);

  logic            busy_q, busy_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  bcdec_pkg::blk_t blk_q;
  bcdec_pkg::pal_t pal_q;

  logic        out_take;
  logic        emit;
  logic        load;
  logic [1:0]  ci;
  logic [23:0] rgb;
  logic [5:0]  apos;
  logic [2:0]  aidx;
  logic [3:0]  a4;
  logic [7:0]  alpha;
  logic [12:0] x;
  logic [12:0] y;
  logic        in_image;

  assign out_take     = !out_valid_q || out_ready_i;
  assign emit         = busy_q && out_take;
  assign load_ready_o = !busy_q || (emit && cnt_q == bcdec_pkg::LAST_PIXEL);
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      cnt_d       = cnt_q + 4'd1;
      if (cnt_q == bcdec_pkg::LAST_PIXEL) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = 4'd0;
    end
  end

  // Pixel select for the current count
  assign ci   = blk_q.indices[{cnt_q, 1'b0} +: 2];
  assign rgb  = pal_q.rgb[ci];
  assign apos = 6'd16 + ({2'b00, cnt_q} * 6'd3);
  assign aidx = blk_q.alpha_bits[apos +: 3];
  assign a4   = blk_q.alpha_bits[{cnt_q, 2'b00} +: 4];
  assign x    = {blk_q.col, cnt_q[1:0]};
  assign y    = {blk_q.row, cnt_q[3:2]};
  assign in_image = ({1'b0, x} < width_i) && ({1'b0, y} < height_i);

  always_comb begin
    if (blk_q.dxt5) begin
      alpha = pal_q.atab[aidx];
    end else if (blk_q.dxt3) begin
      alpha = {a4, a4};
    end else if (ci == 2'd3 && !pal_q.opaque3) begin
      alpha = 8'h00;
    end else begin
      alpha = 8'hFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_i;
      pal_q <= pal_i;
    end
    if (emit) begin
      red_o        <= rgb[23:16];
      green_o      <= rgb[15:8];
      blue_o       <= rgb[7:0];
      alpha_o      <= alpha;
      pixel_x_o    <= x;
      pixel_y_o    <= y;
      inside_res_o <= in_image;
      last_o       <= (cnt_q == bcdec_pkg::LAST_PIXEL);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/bc1_bc2_bc3_block_decoder.sv
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder
// S3TC block decoder: one compressed 4x4 block in, sixteen RGBA pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one compressed block per
//   beat, in raster block order. Output channel (out_valid_o / out_ready_i)
//   gives the block's sixteen pixels in raster order, one beat each, with
//   their image coordinates; last_o marks the sixteenth pixel and
//   inside_res_o is low for pixels beyond the image.
//   Config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0 is
//   the format, 1 the width, 2 the height. Any write to those returns the
//   block position to the image origin. Write only while the block is idle.
//   A block's beat passes the input register and the emitter's block
//   register before its first pixel is registered at the output. The pixel
//   emitter sets the block rate; it drives one pixel per cycle while the
//   output is not stalled. An input register and the emitter's block register
//   let the next block enter while the current one is still streaming.
//   Reset clears the pipe, sets format DXT1, a 1x1 image and position 0,0.
//   When the receiver stalls, the output beat holds and the pipe fills up;
//   in_ready_o drops once both block registers are occupied.
// ----------------------------------------------------------------------------
module bc1_bc2_bc3_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] color0_i,
  input  logic [15:0] color1_i,
  input  logic [31:0] color_indices_i,
  input  logic [63:0] alpha_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [12:0] pixel_x_o,
  output logic [12:0] pixel_y_o,
  output logic        inside_res_o,
  output logic        last_o
);

  logic [1:0]  format_q, format_d;
  logic [13:0] width_q, width_d;
  logic [13:0] height_q, height_d;
  logic [10:0] col_q, col_d;
  logic [10:0] row_q, row_d;
  logic        raw_valid_q, raw_valid_d;
  bcdec_pkg::raw_t raw_q;

  logic        cfg_write;
  logic        cfg_hit;
  logic        in_acc;
  logic        load_ready;
  logic [13:0] w_eff;
  logic [13:0] h_eff;
  logic [14:0] w_sum;
  logic [14:0] h_sum;
  logic [11:0] blocks_x;
  logic [11:0] blocks_y;
  logic [10:0] col_use;
  logic [10:0] row_use;
  logic [11:0] col_inc;
  logic [11:0] row_inc;
  logic        dxt3;
  logic        dxt5;
  logic        four_color;
  bcdec_pkg::pal_t pal;
  bcdec_pkg::blk_t blk;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !raw_valid_q || load_ready;
  assign in_acc      = in_valid_i && in_ready_o;

  assign w_eff    = bcdec_pkg::clamp_dim(width_q);
  assign h_eff    = bcdec_pkg::clamp_dim(height_q);
  assign w_sum    = {1'b0, w_eff} + 15'd3;
  assign h_sum    = {1'b0, h_eff} + 15'd3;
  assign blocks_x = w_sum[13:2];
  assign blocks_y = h_sum[13:2];

  assign dxt5 = format_q[1];
  assign dxt3 = !format_q[1] && format_q[0];

  // Wrap a stale position before use
  assign col_use = ({1'b0, col_q} >= blocks_x) ? 11'd0 : col_q;
  assign row_use = ({1'b0, row_q} >= blocks_y) ? 11'd0 : row_q;
  assign col_inc = {1'b0, col_use} + 12'd1;
  assign row_inc = {1'b0, row_use} + 12'd1;

  always_comb begin
    format_d = format_q;
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_write) begin
      unique case (bcdec_pkg::cfg_idx_e'(cfg_index_i))
        bcdec_pkg::CFG_FORMAT: begin
          format_d = cfg_data_i[1:0];
          cfg_hit  = 1'b1;
        end
        bcdec_pkg::CFG_WIDTH: begin
          width_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        bcdec_pkg::CFG_HEIGHT: begin
          height_d = cfg_data_i;
          cfg_hit  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = 11'd0;
      row_d = 11'd0;
    end else if (in_acc) begin
      if (col_inc >= blocks_x) begin
        col_d = 11'd0;
        row_d = (row_inc >= blocks_y) ? 11'd0 : row_inc[10:0];
      end else begin
        col_d = col_inc[10:0];
        row_d = row_use;
      end
    end
  end

  always_comb begin
    raw_valid_d = raw_valid_q;
    if (load_ready) begin
      raw_valid_d = 1'b0;
    end
    if (in_acc) begin
      raw_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q    <= 2'd0;
      width_q     <= 14'd1;
      height_q    <= 14'd1;
      col_q       <= 11'd0;
      row_q       <= 11'd0;
      raw_valid_q <= 1'b0;
    end else begin
      format_q    <= format_d;
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      raw_valid_q <= raw_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q.color0         <= color0_i;
      raw_q.color1         <= color1_i;
      raw_q.blk.indices    <= color_indices_i;
      raw_q.blk.alpha_bits <= alpha_bits_i;
      raw_q.blk.col        <= col_use;
      raw_q.blk.row        <= row_use;
      raw_q.blk.dxt3       <= dxt3;
      raw_q.blk.dxt5       <= dxt5;
    end
  end

  assign four_color = (raw_q.color0 > raw_q.color1) || raw_q.blk.dxt3 || raw_q.blk.dxt5;
  assign blk        = raw_q.blk;

  bcdec_palette u_palette (
    .color0_i     (raw_q.color0),
    .color1_i     (raw_q.color1),
    .alpha_ends_i (raw_q.blk.alpha_bits[15:0]),
    .four_color_i (four_color),
    .pal_o        (pal)
  );

  bcdec_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (raw_valid_q),
    .load_ready_o (load_ready),
    .blk_i        (blk),
    .pal_i        (pal),
    .width_i      (w_eff),
    .height_i     (h_eff),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .inside_res_o (inside_res_o),
    .last_o       (last_o)
  );

endmodule

// File: rtl/bcdec_checker.sv
// ----------------------------------------------------------------------------
// bcdec_checker
// Port-level checks on the pixel stream of the block decoder.
// ----------------------------------------------------------------------------
module bcdec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [7:0]  alpha_o,
  input logic [12:0] pixel_x_o,
  input logic [12:0] pixel_y_o,
  input logic        inside_res_o,
  input logic        last_o
);

  logic out_beat;
  assign out_beat = out_valid_o && out_ready_i;

  // Stalled beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(red_o) && $stable(green_o) &&
      $stable(blue_o) && $stable(alpha_o) && $stable(inside_res_o) &&
      $stable(last_o))
    else $error("output beat changed while stalled");

  // Last beat of a block is its bottom-right pixel
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (pixel_x_o[1:0] == 2'b11 && pixel_y_o[1:0] == 2'b11)))
    else $error("last flag not on the block corner pixel");

  // Pixels of one block follow without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !last_o |=> out_valid_o)
    else $error("gap inside a block");

  // Column advances by one within a block row
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !last_o |=> pixel_x_o[1:0] == 2'($past(pixel_x_o[1:0]) + 2'd1))
    else $error("pixel column out of order");

endmodule

bind bc1_bc2_bc3_block_decoder bcdec_checker u_bcdec_checker (.*);
